@@ src/pidfd_pkg.sv @@
package pidfd_pkg;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_cmd_type;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PROP_GAIN   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INTEG_GAIN  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DERIV_GAIN  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FILTER_TAU  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LOWER_LIMIT = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UPPER_LIMIT = 3'd5;

   localparam int TAU_WIDTH  = 20;
   localparam int DT_WIDTH   = 19;
   localparam int DIV_WIDTH  = 22;
   localparam int KDE_WIDTH  = 43;
   localparam int TD_WIDTH   = 23;

   localparam logic [31:0]        MAX_DT_US     = 32'd500000;
   localparam logic signed [31:0] US_PER_S      = 32'sd1000000;
   localparam logic signed [31:0] TWO_US_PER_S  = 32'sd2000000;
   localparam logic signed [31:0] UPPER_TEST    = 32'sd16711680;
   localparam logic signed [31:0] UPPER_RESET   = 32'sd16711680;
   localparam logic signed [63:0] DERIV_SAT     = 64'sh0000_0200_0000_0000;
   localparam logic signed [31:0] S32_MAX       = 32'sh7fff_ffff;
   localparam logic signed [31:0] S32_MIN       = 32'sh8000_0000;

endpackage

@@ src/pid_filtered_derivative_controller.sv @@
// PID controller with a Tustin-filtered derivative and conditional integration,
// all gains, limits and the drive in signed Q16.16, times in microseconds. One
// word is worked on at a time. A word whose sample time is zero or above
// 500000 us skips every term and goes from the check straight to delivery.
// Otherwise the terms go one after another through a shared bit-serial
// multiply/divide unit: each multiply works through max(SAMPLE_WIDTH+1, 21)
// multiplier bits, each divide through max(SAMPLE_WIDTH+50, 64) dividend bits,
// and a word that runs every term does six multiplies and two divides. A zero
// derivative gain skips three multiplies and one divide, and an integral step
// that is not taken skips two multiplies and a divide. The next word is taken
// once the result is in the output register.
module pid_filtered_derivative_controller #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]           req_setpoint,
   input  logic signed [SAMPLE_WIDTH-1:0]           req_measured,
   input  logic [31:0]                              req_now_us,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [31:0]                       rsp_drive,
   output logic                                     rsp_updated,
   input  logic                                     csr_we,
   input  logic [pidfd_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [pidfd_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import pidfd_pkg::*;

   localparam int MAG_W  = (SAMPLE_WIDTH + 50 > 64) ? SAMPLE_WIDTH + 50 : 64;
   localparam int P_W    = MAG_W + 1;
   localparam int MULB_W = (SAMPLE_WIDTH + 1 > 21) ? SAMPLE_WIDTH + 1 : 21;
   localparam int E_W    = SAMPLE_WIDTH + 1;
   localparam int DE_W   = SAMPLE_WIDTH + 2;
   localparam int PT_W   = SAMPLE_WIDTH + 33;
   localparam int U_W    = SAMPLE_WIDTH + 35;
   localparam int X_W    = SAMPLE_WIDTH + 33;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_PROP,
      S_DGAIN,
      S_DSCALE,
      S_DHIST,
      S_DDIV,
      S_ITEST,
      S_IGAIN,
      S_ISCALE,
      S_IDIV,
      S_SUM,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic signed [31:0]          kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   logic [TAU_WIDTH-1:0]        tau_ff, tau_in;
   logic signed [31:0]          lower_ff, lower_in, upper_ff, upper_in;

   logic [31:0]                 last_time_ff, last_time_in;
   logic signed [E_W-1:0]       last_error_ff, last_error_in;
   logic signed [31:0]          deriv_acc_ff, deriv_acc_in;
   logic signed [31:0]          integ_acc_ff, integ_acc_in;
   logic signed [31:0]          last_drive_ff, last_drive_in;

   logic signed [SAMPLE_WIDTH-1:0] sp_ff, sp_in, ms_ff, ms_in;
   logic [31:0]                 now_ff, now_in;
   logic signed [E_W-1:0]       e_ff, e_in;
   logic [DT_WIDTH-1:0]         dt_ff, dt_in;
   logic signed [PT_W-1:0]      p_ff, p_in;
   logic signed [KDE_WIDTH-1:0] kde_ff, kde_in;
   logic signed [P_W-1:0]       num_ff, num_in;
   logic signed [31:0]          d_ff, d_in;
   logic                        upd_ff, upd_in;

   logic                        issued_ff, issued_in;
   unit_cmd_type                cmd_ff, cmd_in;
   logic signed [P_W-1:0]       opa_ff, opa_in, opb_ff, opb_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]          rsp_drive_ff, rsp_drive_in;
   logic                        rsp_updated_ff, rsp_updated_in;

   logic                        unit_done;
   logic signed [P_W-1:0]       unit_result;

   logic [31:0]                 dt_full;
   logic signed [DE_W-1:0]      de;
   logic signed [TD_WIDTH-1:0]  tdiff;
   logic [DIV_WIDTH-1:0]        tsum;
   logic signed [U_W-1:0]       u;
   logic signed [X_W-1:0]       x;

   pidfd_serial_unit #(
      .MAG_WIDTH  (MAG_W),
      .MULB_WIDTH (MULB_W),
      .DIVR_WIDTH (DIV_WIDTH)
   ) u_unit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd_ff),
      .opa    (opa_ff),
      .opb    (opb_ff),
      .done   (unit_done),
      .result (unit_result)
   );

   always_comb begin
      dt_full = now_ff - last_time_ff;
      de      = DE_W'(e_ff) - DE_W'(last_error_ff);
      tdiff   = TD_WIDTH'({tau_ff, 1'b0}) - TD_WIDTH'(dt_ff);
      tsum    = DIV_WIDTH'({tau_ff, 1'b0}) + DIV_WIDTH'(dt_ff);
      u       = U_W'(p_ff) + U_W'(integ_acc_ff) + U_W'(d_ff);
      x       = X_W'(integ_acc_ff) + X_W'(unit_result);

      state_in      = state_ff;
      kp_in         = kp_ff;
      ki_in         = ki_ff;
      kd_in         = kd_ff;
      tau_in        = tau_ff;
      lower_in      = lower_ff;
      upper_in      = upper_ff;
      last_time_in  = last_time_ff;
      last_error_in = last_error_ff;
      deriv_acc_in  = deriv_acc_ff;
      integ_acc_in  = integ_acc_ff;
      last_drive_in = last_drive_ff;
      sp_in         = sp_ff;
      ms_in         = ms_ff;
      now_in        = now_ff;
      e_in          = e_ff;
      dt_in         = dt_ff;
      p_in          = p_ff;
      kde_in        = kde_ff;
      num_in        = num_ff;
      d_in          = d_ff;
      upd_in        = upd_ff;
      issued_in     = issued_ff;
      cmd_in        = '{start: 1'b0, op: cmd_ff.op};
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_drive_in   = rsp_drive_ff;
      rsp_updated_in = rsp_updated_ff;

      if (csr_we) begin
         unique case (csr_index)
            REG_PROP_GAIN:   kp_in    = $signed(csr_wdata);
            REG_INTEG_GAIN:  ki_in    = $signed(csr_wdata);
            REG_DERIV_GAIN:  kd_in    = $signed(csr_wdata);
            REG_FILTER_TAU:  tau_in   = csr_wdata[TAU_WIDTH-1:0];
            REG_LOWER_LIMIT: lower_in = $signed(csr_wdata);
            REG_UPPER_LIMIT: upper_in = $signed(csr_wdata);
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sp_in    = req_setpoint;
               ms_in    = req_measured;
               now_in   = req_now_us;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            last_time_in = now_ff;
            if (dt_full == '0 || dt_full > MAX_DT_US) begin
               upd_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               e_in     = E_W'(sp_ff) - E_W'(ms_ff);
               dt_in    = dt_full[DT_WIDTH-1:0];
               upd_in   = 1'b1;
               state_in = S_PROP;
            end
         end
         S_PROP: begin
            if (!issued_ff) begin
               issued_in = 1'b1;
               cmd_in    = '{start: 1'b1, op: OP_MUL};
               opa_in    = P_W'(kp_ff);
               opb_in    = P_W'(e_ff);
            end else if (unit_done) begin
               issued_in = 1'b0;
               p_in      = unit_result[PT_W-1:0];
               if (kd_ff != '0) begin
                  state_in = S_DGAIN;
               end else begin
                  d_in     = '0;
                  state_in = S_ITEST;
               end
            end
         end
         S_DGAIN: begin
            if (!issued_ff) begin
               issued_in = 1'b1;
               cmd_in    = '{start: 1'b1, op: OP_MUL};
               opa_in    = P_W'(kd_ff);
               opb_in    = P_W'(de);
            end else if (unit_done) begin
               issued_in = 1'b0;
               if (unit_result > P_W'(DERIV_SAT)) begin
                  kde_in = KDE_WIDTH'(DERIV_SAT);
               end else if (unit_result < -P_W'(DERIV_SAT)) begin
                  kde_in = -KDE_WIDTH'(DERIV_SAT);
               end else begin
                  kde_in = unit_result[KDE_WIDTH-1:0];
               end
               state_in = S_DSCALE;
            end
         end
         S_DSCALE: begin
            if (!issued_ff) begin
               issued_in = 1'b1;
               cmd_in    = '{start: 1'b1, op: OP_MUL};
               opa_in    = P_W'(kde_ff);
               opb_in    = P_W'(TWO_US_PER_S);
            end else if (unit_done) begin
               issued_in = 1'b0;
               num_in    = unit_result;
               state_in  = S_DHIST;
            end
         end
         S_DHIST: begin
            if (!issued_ff) begin
               issued_in = 1'b1;
               cmd_in    = '{start: 1'b1, op: OP_MUL};
               opa_in    = P_W'(deriv_acc_ff);
               opb_in    = P_W'(tdiff);
            end else if (unit_done) begin
               issued_in = 1'b0;
               num_in    = num_ff + unit_result;
               state_in  = S_DDIV;
            end
         end
         S_DDIV: begin
            if (!issued_ff) begin
               issued_in = 1'b1;
               cmd_in    = '{start: 1'b1, op: OP_DIV};
               opa_in    = num_ff;
               opb_in    = P_W'(tsum);
            end else if (unit_done) begin
               issued_in = 1'b0;
               if (unit_result > P_W'(S32_MAX)) begin
                  d_in = S32_MAX;
               end else if (unit_result < P_W'(S32_MIN)) begin
                  d_in = S32_MIN;
               end else begin
                  d_in = unit_result[31:0];
               end
               state_in = S_ITEST;
            end
         end
         S_ITEST: begin
            if (ki_ff == '0) begin
               integ_acc_in = '0;
               state_in     = S_SUM;
            end else if (u > 0 && u < U_W'(UPPER_TEST)) begin
               state_in = S_IGAIN;
            end else begin
               state_in = S_SUM;
            end
         end
         S_IGAIN: begin
            if (!issued_ff) begin
               issued_in = 1'b1;
               cmd_in    = '{start: 1'b1, op: OP_MUL};
               opa_in    = P_W'(ki_ff);
               opb_in    = P_W'(e_ff);
            end else if (unit_done) begin
               issued_in = 1'b0;
               num_in    = unit_result;
               state_in  = S_ISCALE;
            end
         end
         S_ISCALE: begin
            if (!issued_ff) begin
               issued_in = 1'b1;
               cmd_in    = '{start: 1'b1, op: OP_MUL};
               opa_in    = num_ff;
               opb_in    = P_W'(dt_ff);
            end else if (unit_done) begin
               issued_in = 1'b0;
               num_in    = unit_result;
               state_in  = S_IDIV;
            end
         end
         S_IDIV: begin
            if (!issued_ff) begin
               issued_in = 1'b1;
               cmd_in    = '{start: 1'b1, op: OP_DIV};
               opa_in    = num_ff;
               opb_in    = P_W'(US_PER_S);
            end else if (unit_done) begin
               issued_in = 1'b0;
               if (x < X_W'(lower_ff)) begin
                  integ_acc_in = lower_ff;
               end else if (x > X_W'(upper_ff)) begin
                  integ_acc_in = upper_ff;
               end else begin
                  integ_acc_in = x[31:0];
               end
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            last_drive_in = p_ff[31:0] + integ_acc_ff + d_ff;
            deriv_acc_in  = d_ff;
            last_error_in = e_ff;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_drive_in   = last_drive_ff;
               rsp_updated_in = upd_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         kp_ff         <= '0;
         ki_ff         <= '0;
         kd_ff         <= '0;
         tau_ff        <= '0;
         lower_ff      <= '0;
         upper_ff      <= UPPER_RESET;
         last_time_ff  <= '0;
         last_error_ff <= '0;
         deriv_acc_ff  <= '0;
         integ_acc_ff  <= '0;
         last_drive_ff <= '0;
         issued_ff     <= 1'b0;
         cmd_ff        <= '{start: 1'b0, op: OP_MUL};
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         kp_ff         <= kp_in;
         ki_ff         <= ki_in;
         kd_ff         <= kd_in;
         tau_ff        <= tau_in;
         lower_ff      <= lower_in;
         upper_ff      <= upper_in;
         last_time_ff  <= last_time_in;
         last_error_ff <= last_error_in;
         deriv_acc_ff  <= deriv_acc_in;
         integ_acc_ff  <= integ_acc_in;
         last_drive_ff <= last_drive_in;
         issued_ff     <= issued_in;
         cmd_ff        <= cmd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sp_ff          <= sp_in;
      ms_ff          <= ms_in;
      now_ff         <= now_in;
      e_ff           <= e_in;
      dt_ff          <= dt_in;
      p_ff           <= p_in;
      kde_ff         <= kde_in;
      num_ff         <= num_in;
      d_ff           <= d_in;
      upd_ff         <= upd_in;
      opa_ff         <= opa_in;
      opb_ff         <= opb_in;
      rsp_drive_ff   <= rsp_drive_in;
      rsp_updated_ff <= rsp_updated_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_updated = rsp_updated_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("word taken while another is in flight");

   assert property (@(posedge clock) disable iff (reset)
      unit_done |-> issued_ff)
      else $error("arithmetic unit finished without a pending operation");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE))
      else $error("result word raised outside the delivery step");
`endif

endmodule

@@ src/pidfd_serial_unit.sv @@
module pidfd_serial_unit #(
   parameter int MAG_WIDTH  = 66,
   parameter int MULB_WIDTH = 21,
   parameter int DIVR_WIDTH = 22
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pidfd_pkg::unit_cmd_type    cmd,
   input  logic signed [MAG_WIDTH:0]  opa,
   input  logic signed [MAG_WIDTH:0]  opb,
   output logic                       done,
   output logic signed [MAG_WIDTH:0]  result
);
   import pidfd_pkg::*;

   localparam int CNT_W = $clog2(MAG_WIDTH + 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MULB_WIDTH - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_WIDTH - 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   unit_op_type             op_ff, op_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;
   logic [MAG_WIDTH-1:0]    acc_ff, acc_in;
   logic [MAG_WIDTH-1:0]    mcand_ff, mcand_in;
   logic [MULB_WIDTH-1:0]   mplier_ff, mplier_in;
   logic [DIVR_WIDTH-1:0]   rem_ff, rem_in;
   logic [DIVR_WIDTH-1:0]   dvsr_ff, dvsr_in;

   logic signed [MAG_WIDTH:0] abs_a, abs_b, mag;
   logic [DIVR_WIDTH:0]       rem_sh;
   logic                      fits;
   logic                      last;

   always_comb begin
      abs_a  = opa[MAG_WIDTH] ? -opa : opa;
      abs_b  = opb[MAG_WIDTH] ? -opb : opb;
      rem_sh = {rem_ff, acc_ff[MAG_WIDTH-1]};
      fits   = rem_sh >= {1'b0, dvsr_ff};
      last   = (op_ff == OP_MUL) ? (cnt_ff == MUL_LAST) : (cnt_ff == DIV_LAST);

      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      dvsr_in   = dvsr_ff;

      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = '0;
         neg_in  = opa[MAG_WIDTH] ^ opb[MAG_WIDTH];
         if (cmd.op == OP_MUL) begin
            acc_in    = '0;
            mcand_in  = abs_a[MAG_WIDTH-1:0];
            mplier_in = abs_b[MULB_WIDTH-1:0];
         end else begin
            acc_in  = abs_a[MAG_WIDTH-1:0];
            rem_in  = '0;
            dvsr_in = abs_b[DIVR_WIDTH-1:0];
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (op_ff == OP_MUL) begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[MAG_WIDTH-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[MULB_WIDTH-1:1]};
         end else begin
            if (fits) begin
               rem_in = DIVR_WIDTH'(rem_sh - {1'b0, dvsr_ff});
            end else begin
               rem_in = rem_sh[DIVR_WIDTH-1:0];
            end
            acc_in = {acc_ff[MAG_WIDTH-2:0], fits};
         end
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end

      mag    = $signed({1'b0, acc_ff});
      result = neg_ff ? -mag : mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff     <= op_in;
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      dvsr_ff   <= dvsr_in;
   end

   assign done = done_ff;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

class pid_scoreboard;
   longint signed kp, ki, kd, lo_lim, hi_lim;
   longint unsigned tau;
   bit [31:0] prev_time;
   longint signed prev_err, d_acc, i_acc;
   bit [31:0] prev_drive;
   bit [31:0] drive_q[$];
   bit updated_q[$];
   int errors;
   int checked;
   int n_updated;

   function new();
      kp = 0; ki = 0; kd = 0; tau = 0; lo_lim = 0; hi_lim = 16711680;
      prev_time = 0; prev_err = 0; d_acc = 0; i_acc = 0; prev_drive = 0;
      errors = 0; checked = 0; n_updated = 0;
   endfunction

   function void set_reg(bit [2:0] idx, bit [31:0] val);
      case (idx)
         pidfd_pkg::REG_PROP_GAIN: begin
            kp = longint'(signed'(val));
         end
         pidfd_pkg::REG_INTEG_GAIN: begin
            ki = longint'(signed'(val));
         end
         pidfd_pkg::REG_DERIV_GAIN: begin
            kd = longint'(signed'(val));
         end
         pidfd_pkg::REG_FILTER_TAU: begin
            tau = val[19:0];
         end
         pidfd_pkg::REG_LOWER_LIMIT: begin
            lo_lim = longint'(signed'(val));
         end
         pidfd_pkg::REG_UPPER_LIMIT: begin
            hi_lim = longint'(signed'(val));
         end
         default: ;
      endcase
   endfunction

   function void note_word(bit [15:0] sp, bit [15:0] ms, bit [31:0] now);
      bit [31:0] dt;
      longint signed e, p, d, kde, t2, num, q, u, ke, x, sum;
      dt = now - prev_time;
      if (dt == 0 || dt > 500000) begin
         prev_time = now;
         drive_q.push_back(prev_drive);
         updated_q.push_back(1'b0);
         return;
      end
      e = longint'(signed'(sp)) - longint'(signed'(ms));
      p = (kp != 0) ? kp * e : 0;
      if (kd != 0) begin
         kde = kd * (e - prev_err);
         if (kde > (64'sd1 <<< 41)) kde = 64'sd1 <<< 41;
         if (kde < -(64'sd1 <<< 41)) kde = -(64'sd1 <<< 41);
         t2 = 2 * longint'(tau);
         num = kde * 2000000 + (t2 - longint'(dt)) * d_acc;
         q = num / (t2 + longint'(dt));
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
         d = q;
      end else begin
         d = 0;
      end
      d_acc = d;
      if (ki != 0) begin
         u = p + i_acc + d;
         if (u > 0 && u < 16711680) begin
            ke = ki * e;
            x = i_acc + (ke / 1000000) * longint'(dt) + ((ke % 1000000) * longint'(dt)) / 1000000;
            if (x < lo_lim) x = lo_lim;
            else if (x > hi_lim) x = hi_lim;
            i_acc = x;
         end
      end else begin
         i_acc = 0;
      end
      sum = p + i_acc + d;
      prev_drive = sum[31:0];
      prev_err = e;
      prev_time = now;
      drive_q.push_back(prev_drive);
      updated_q.push_back(1'b1);
   endfunction

   function void check_word(bit [31:0] drive, bit updated);
      bit [31:0] exp_drive;
      bit exp_upd;
      checked++;
      if (drive_q.size() == 0) begin
         $error("unexpected word: drive %h updated %0d", drive, updated);
         errors++;
         return;
      end
      exp_drive = drive_q.pop_front();
      exp_upd = updated_q.pop_front();
      if (exp_upd) n_updated++;
      if (drive !== exp_drive) begin
         $error("drive: expected %h actual %h", exp_drive, drive);
         errors++;
      end
      if (updated !== exp_upd) begin
         $error("updated: expected %0d actual %0d", exp_upd, updated);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import pidfd_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [15:0] req_setpoint = 0;
   logic signed [15:0] req_measured = 0;
   logic [31:0] req_now_us = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_drive;
   logic rsp_updated;
   logic csr_we = 0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = 0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = 0;

   pid_scoreboard sb = new();
   bit [31:0] t_now = 0;
   int idle_cycles = 0;
   int n_sent = 0;

   pid_filtered_derivative_controller DUT (.*);

   always #1 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   task automatic write_reg(bit [2:0] idx, bit [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   task automatic send_word(bit [15:0] sp, bit [15:0] ms, bit [31:0] now);
      int g;
      g = gap_len();
      repeat (g + 1) @(posedge clock);
      req_valid <= 1'b1;
      req_setpoint <= sp;
      req_measured <= ms;
      req_now_us <= now;
      do @(posedge clock); while (!req_ready);
      sb.note_word(sp, ms, now);
      n_sent++;
      req_valid <= 1'b0;
   endtask

   task automatic send_dt(bit [15:0] sp, bit [15:0] ms, bit [31:0] dt);
      t_now = t_now + dt;
      send_word(sp, ms, t_now);
   endtask

   task automatic drain();
      while (sb.drive_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic bit [31:0] rand_dt();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 0;
      if (r < 6) return $urandom_range(500001, 32'hffffffff);
      if (r < 9) return 500000;
      if (r < 60) return $urandom_range(1, 2000);
      return $urandom_range(1, 500000);
   endfunction

   function automatic bit [15:0] rand_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h8000;
      if (r == 1) return 16'h7fff;
      if (r < 6) return $urandom_range(0, 400) - 200;
      return $urandom;
   endfunction

   function automatic bit [31:0] rand_gain();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return 32'h7fffffff;
      if (r == 2) return 32'h80000000;
      if (r < 7) return $urandom_range(0, 32'h40000) - 32'h20000;
      return $urandom;
   endfunction

   task automatic random_config();
      bit [31:0] a, b;
      write_reg(REG_PROP_GAIN, rand_gain());
      write_reg(REG_INTEG_GAIN, rand_gain());
      write_reg(REG_DERIV_GAIN, rand_gain());
      case ($urandom_range(0, 3))
         0: write_reg(REG_FILTER_TAU, 0);
         1: write_reg(REG_FILTER_TAU, 1000000);
         default: write_reg(REG_FILTER_TAU, $urandom_range(0, 20000));
      endcase
      if ($urandom_range(0, 4) == 0) begin
         a = $urandom;
         b = $urandom;
      end else begin
         a = -$urandom_range(0, 32'h00ff0000);
         b = $urandom_range(0, 32'h00ff0000);
      end
      write_reg(REG_LOWER_LIMIT, a);
      write_reg(REG_UPPER_LIMIT, b);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_word(rsp_drive, rsp_updated);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 5000) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      int g;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 3) == 0) begin
            g = gap_len();
            if (g > 0) begin
               rsp_ready <= 1'b0;
               repeat (g) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // directed
      send_dt(16'sd100, 16'sd0, 0);
      drain();
      write_reg(REG_PROP_GAIN, 32'h00010000);
      write_reg(REG_INTEG_GAIN, 32'h00100000);
      write_reg(REG_DERIV_GAIN, 32'h00000100);
      write_reg(REG_FILTER_TAU, 1000);
      write_reg(REG_LOWER_LIMIT, 32'hff000000);
      write_reg(REG_UPPER_LIMIT, 32'h00ff0000);
      send_dt(16'sd10, 16'sd5, 1);
      send_dt(16'sd10, 16'sd5, 1000);
      send_dt(16'sh7fff, 16'sh8000, 500000);
      send_dt(16'sh8000, 16'sh7fff, 500001);
      send_dt(16'sd3, 16'sd1, 0);
      send_dt(16'sd3, 16'sd1, 32'hffffffff);
      send_dt(16'sd1, 16'sd0, 10);
      send_dt(16'sd0, 16'sd1, 10);
      drain();
      write_reg(REG_PROP_GAIN, 32'h80000000);
      write_reg(REG_DERIV_GAIN, 32'h7fffffff);
      write_reg(REG_FILTER_TAU, 1000000);
      write_reg(REG_INTEG_GAIN, 32'h7fffffff);
      write_reg(REG_LOWER_LIMIT, 32'h80000000);
      write_reg(REG_UPPER_LIMIT, 32'h7fffffff);
      send_dt(16'sh7fff, 16'sh8000, 7);
      send_dt(16'sh8000, 16'sh7fff, 1);
      send_dt(16'sd0, 16'sd0, 300);
      drain();
      write_reg(REG_PROP_GAIN, 0);
      write_reg(REG_DERIV_GAIN, 0);
      write_reg(REG_FILTER_TAU, 0);
      write_reg(REG_INTEG_GAIN, 32'h00010000);
      send_dt(16'sd50, 16'sd0, 1000);
      send_dt(16'sd50, 16'sd0, 1000);
      send_dt(16'sd1, 16'sd0, 1);
      drain();
      // random phases
      while (n_sent < 1810) begin
         random_config();
         repeat ($urandom_range(20, 150)) begin
            if ($urandom_range(0, 20) == 0) send_word(rand_sample(), rand_sample(), $urandom);
            else send_dt(rand_sample(), rand_sample(), rand_dt());
         end
         drain();
      end
      drain();
      $display("covered %0d words, %0d results (%0d with updated terms)", n_sent,
               sb.checked, sb.n_updated);
      if (sb.errors == 0 && sb.drive_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
